// File: design/lgge_pkg.sv
// Shared types and constants of the life grid generation engine.
`timescale 1ns / 1ps
`default_nettype none
package lgge_pkg;

    localparam int LGGE_MAX_WIDTH  = 64;
    localparam int LGGE_MAX_HEIGHT = 64;

    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int COORD_W    = 6;

    localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_STEP  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t               command;
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic               write_value;
    } in_item_t;

    typedef struct packed {
        logic cell_alive;
        logic coord_error;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic sweep_run;
        logic access;
        logic gen_run;
        logic result;
    } ctrl_t;

    typedef struct packed {
        logic sweep_last;
        logic gen_last;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

// File: design/lgge_stream_if.sv
// Valid/ready item channel with a typed payload.
`timescale 1ns / 1ps
`default_nettype none
interface lgge_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/lgge_ctrl.sv
// Command sequencer of the life grid generation engine.
`timescale 1ns / 1ps
`default_nettype none
module lgge_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire lgge_pkg::cmd_t in_command,
    input  wire lgge_pkg::stat_t stat,
    output logic                in_ready,
    output lgge_pkg::ctrl_t     dp_ctrl
);
    import lgge_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ACCESS,
        ST_CLEAR,
        ST_GEN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        in_ready          = (state_reg == ST_IDLE);
        dp_ctrl.load      = in_valid && in_ready;
        dp_ctrl.sweep_run = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
        dp_ctrl.access    = (state_reg == ST_ACCESS);
        dp_ctrl.gen_run   = (state_reg == ST_GEN);
        dp_ctrl.result    = (state_reg == ST_RESULT) && stat.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_command) inside
                        CMD_WRITE, CMD_READ: state_next = ST_ACCESS;
                        CMD_CLEAR:           state_next = ST_CLEAR;
                        default:             state_next = ST_GEN;
                    endcase
                end
            end
            ST_ACCESS:
            begin
                state_next = ST_RESULT;
            end
            ST_CLEAR:
            begin
                if (stat.sweep_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_GEN:
            begin
                if (stat.gen_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: design/lgge_datapath.sv
// Cell store, column line buffers, neighbor window and result register.
`timescale 1ns / 1ps
`default_nettype none
module lgge_datapath #(
    parameter int MAX_WIDTH  = lgge_pkg::LGGE_MAX_WIDTH,
    parameter int MAX_HEIGHT = lgge_pkg::LGGE_MAX_HEIGHT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lgge_pkg::ctrl_t                   dp_ctrl,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    active_w,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   active_h,
    input  wire lgge_pkg::in_item_t                in_item,
    input  wire logic                              out_ready,
    output lgge_pkg::stat_t                        stat,
    output logic                                   out_valid,
    output lgge_pkg::out_item_t                    out_item
);
    import lgge_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int YAW   = $clog2(MAX_HEIGHT);
    localparam int XCW   = (XW > COORD_W) ? XW : COORD_W;
    localparam int YCW   = (YW > COORD_W) ? YW : COORD_W;

    logic cell_mem [DEPTH];
    logic col_buf0 [MAX_HEIGHT];
    logic col_buf1 [MAX_HEIGHT];

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_rdata_reg;

    cmd_t          cmd_reg;
    logic          err_reg;
    logic          wv_reg;
    logic [AW-1:0] addr_reg;
    logic          item_err;

    logic [AW-1:0] sweep_reg;

    logic [XW-1:0] gx_reg;
    logic [YW-1:0] gy_reg;
    logic [AW-1:0] gbase_reg;
    logic          par_reg;
    logic          g_col_ok;
    logic          g_row_ok;
    logic [AW-1:0] g_addr;
    logic [YAW-1:0] g_yidx;

    logic           s1_valid_reg;
    logic [AW-1:0]  s1_addr_reg;
    logic           s1_col_ok_reg;
    logic           s1_row_ok_reg;
    logic           s1_has1_reg;
    logic           s1_has2_reg;
    logic           s1_y0_reg;
    logic           s1_par_reg;
    logic [YAW-1:0] s1_yidx_reg;
    logic           buf0_rd_reg;
    logic           buf1_rd_reg;

    logic [2:0] win_a_reg;
    logic [2:0] win_b_reg;
    logic [2:0] triple;
    logic [3:0] nbr_count;
    logic       new_cell;
    logic       s1_we;

    logic out_valid_reg;
    logic out_alive_reg;
    logic out_err_reg;

    assign item_err = ((in_item.command == CMD_WRITE) || (in_item.command == CMD_READ))
                      && ((XCW'(in_item.x_pos) >= XCW'(active_w))
                          || (YCW'(in_item.y_pos) >= YCW'(active_h)));

    always_ff @(posedge clk)
    begin
        if (dp_ctrl.load)
        begin
            cmd_reg  <= in_item.command;
            err_reg  <= item_err;
            wv_reg   <= in_item.write_value;
            addr_reg <= AW'(in_item.x_pos) * AW'(MAX_HEIGHT) + AW'(in_item.y_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (dp_ctrl.load)
        begin
            sweep_reg <= '0;
        end
        else if (dp_ctrl.sweep_run)
        begin
            sweep_reg <= sweep_reg + AW'(1);
        end
    end

    assign stat.sweep_last = (sweep_reg == AW'(DEPTH - 1));

    assign g_col_ok = (gx_reg < active_w);
    assign g_row_ok = (gy_reg < active_h);
    assign g_addr   = gbase_reg + AW'(gy_reg);
    assign g_yidx   = gy_reg[YAW-1:0];

    assign stat.gen_last = (gx_reg == active_w) && (gy_reg == active_h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gx_reg       <= '0;
            gy_reg       <= '0;
            gbase_reg    <= '0;
            par_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= dp_ctrl.gen_run;
            if (dp_ctrl.load)
            begin
                gx_reg    <= '0;
                gy_reg    <= '0;
                gbase_reg <= '0;
                par_reg   <= 1'b0;
            end
            else if (dp_ctrl.gen_run)
            begin
                if (gy_reg == active_h)
                begin
                    gy_reg    <= '0;
                    gx_reg    <= gx_reg + XW'(1);
                    gbase_reg <= gbase_reg + AW'(MAX_HEIGHT);
                    par_reg   <= !par_reg;
                end
                else
                begin
                    gy_reg <= gy_reg + YW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_ctrl.gen_run)
        begin
            s1_addr_reg   <= g_addr;
            s1_col_ok_reg <= g_col_ok;
            s1_row_ok_reg <= g_row_ok;
            s1_has1_reg   <= (gx_reg != '0);
            s1_has2_reg   <= (gx_reg > XW'(1));
            s1_y0_reg     <= (gy_reg == '0);
            s1_par_reg    <= par_reg;
            s1_yidx_reg   <= g_yidx;
        end
    end

    // Column line buffers hold the two previous columns of the old grid.
    always_ff @(posedge clk)
    begin
        if (dp_ctrl.gen_run && g_row_ok)
        begin
            buf0_rd_reg <= col_buf0[g_yidx];
        end
        if (s1_valid_reg && s1_row_ok_reg && s1_col_ok_reg && !s1_par_reg)
        begin
            col_buf0[s1_yidx_reg] <= mem_rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_ctrl.gen_run && g_row_ok)
        begin
            buf1_rd_reg <= col_buf1[g_yidx];
        end
        if (s1_valid_reg && s1_row_ok_reg && s1_col_ok_reg && s1_par_reg)
        begin
            col_buf1[s1_yidx_reg] <= mem_rdata_reg;
        end
    end

    always_comb
    begin
        triple[0] = s1_row_ok_reg && s1_col_ok_reg && mem_rdata_reg;
        triple[1] = s1_row_ok_reg && s1_has1_reg
                    && (s1_par_reg ? buf0_rd_reg : buf1_rd_reg);
        triple[2] = s1_row_ok_reg && s1_has2_reg
                    && (s1_par_reg ? buf1_rd_reg : buf0_rd_reg);
        nbr_count = 4'($countones({win_a_reg, win_b_reg[2], win_b_reg[0], triple}));
        new_cell  = (nbr_count == 4'd3) || (win_b_reg[1] && (nbr_count == 4'd2));
        s1_we     = s1_valid_reg && s1_has1_reg && !s1_y0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            win_a_reg <= s1_y0_reg ? 3'b000 : win_b_reg;
            win_b_reg <= triple;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = 1'b0;
        if (dp_ctrl.sweep_run)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
        end
        else if (dp_ctrl.access && (cmd_reg == CMD_WRITE) && !err_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = addr_reg;
            mem_wdata = wv_reg;
        end
        else if (s1_we)
        begin
            mem_we    = 1'b1;
            mem_waddr = s1_addr_reg - AW'(MAX_HEIGHT + 1);
            mem_wdata = new_cell;
        end
    end

    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        if (dp_ctrl.access)
        begin
            mem_re    = !err_reg;
            mem_raddr = addr_reg;
        end
        else if (dp_ctrl.gen_run)
        begin
            mem_re    = g_col_ok && g_row_ok;
            mem_raddr = g_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_rdata_reg <= cell_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_ctrl.result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_ctrl.result)
        begin
            out_alive_reg <= (cmd_reg == CMD_READ) && !err_reg && mem_rdata_reg;
            out_err_reg   <= err_reg;
        end
    end

    assign stat.out_free        = !out_valid_reg || out_ready;
    assign out_valid            = out_valid_reg;
    assign out_item.cell_alive  = out_alive_reg;
    assign out_item.coord_error = out_err_reg;

endmodule
`default_nettype wire

// File: design/life_grid_generation_engine.sv
// Top level of the life grid engine: configuration registers and channel wiring.
//
// Usage:
//   in_chan carries one command item (write cell, read cell, clear grid,
//   advance one generation under rule B3/S23); out_chan returns exactly one
//   result item per command. The cfg port writes grid_width (index 0) or
//   grid_height (index 1), one per write; write them only while the block is idle.
//   Read and write pass an access state, then a result state; clear sweeps
//   all MAX_WIDTH*MAX_HEIGHT cells; a generation scans (w+1)*(h+1) positions
//   for the active w by h grid, then drains. The generation scans one cell
//   per cycle through the single-write, single-read cell memory, with two
//   column line buffers holding the old neighbor columns.
//   One command is in work at a time; the next is taken once the previous
//   result sits in the output register.
//   After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells zeroes the
//   cell memory; no item is taken during it. Size registers reset to 64.
//   When the receiver stalls, the result holds in the output register and the
//   block takes one more command, then holds that result until the register
//   frees up.
`timescale 1ns / 1ps
`default_nettype none
module life_grid_generation_engine #(
    parameter int MAX_WIDTH  = lgge_pkg::LGGE_MAX_WIDTH,
    parameter int MAX_HEIGHT = lgge_pkg::LGGE_MAX_HEIGHT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [lgge_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lgge_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    lgge_stream_if.sink                            in_chan,
    lgge_stream_if.source                          out_chan
);
    import lgge_pkg::*;

    localparam int XW  = $clog2(MAX_WIDTH + 1);
    localparam int YW  = $clog2(MAX_HEIGHT + 1);
    localparam int WCW = (XW > CFG_DATA_W) ? XW : CFG_DATA_W;
    localparam int HCW = (YW > CFG_DATA_W) ? YW : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] grid_width_reg;
    logic [CFG_DATA_W-1:0] grid_height_reg;
    logic [WCW-1:0]        width_ext;
    logic [HCW-1:0]        height_ext;
    logic [XW-1:0]         active_w;
    logic [YW-1:0]         active_h;

    ctrl_t     dp_ctrl;
    stat_t     stat;
    logic      in_ready;
    logic      out_valid;
    out_item_t out_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_SIZE_RESET;
            grid_height_reg <= GRID_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_wdata;
                default:         grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    // Clamp sizes to the storage bounds.
    assign width_ext  = WCW'(grid_width_reg);
    assign height_ext = HCW'(grid_height_reg);
    assign active_w   = (width_ext > WCW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(width_ext);
    assign active_h   = (height_ext > HCW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(height_ext);

    lgge_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_chan.valid),
        .in_command (in_chan.payload.command),
        .stat       (stat),
        .in_ready   (in_ready),
        .dp_ctrl    (dp_ctrl)
    );

    lgge_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_ctrl   (dp_ctrl),
        .active_w  (active_w),
        .active_h  (active_h),
        .in_item   (in_chan.payload),
        .out_ready (out_chan.ready),
        .stat      (stat),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign in_chan.ready    = in_ready;
    assign out_chan.valid   = out_valid;
    assign out_chan.payload = out_item;

endmodule
`default_nettype wire

// File: tb/life_grid_generation_engine_tb.sv
// Self-checking testbench of the life grid engine against a grid predictor.
`timescale 1ns / 1ps
module life_grid_generation_engine_tb;
    import lgge_pkg::*;

    localparam int GRID_CELLS      = LGGE_MAX_WIDTH * LGGE_MAX_HEIGHT;
    localparam int WATCHDOG_LIMIT  = 40000;
    localparam int HOLD_OFF_CYCLES = 9000;
    localparam int RANDOM_ITEMS    = 112;
    localparam int PHASE_ITEMS     = 24;
    localparam int PRESSURE_PHASE  = 2;

    class life_grid_scoreboard;
        bit [GRID_CELLS-1:0]   cells;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        out_item_t             pending_results[$];
        int                    mismatches;
        int                    result_count;

        function new();
            cells        = '0;
            width_reg    = GRID_SIZE_RESET;
            height_reg   = GRID_SIZE_RESET;
            mismatches   = 0;
            result_count = 0;
        endfunction

        function void set_size(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] reg_value);
            if (index == CFG_GRID_WIDTH)
                width_reg = reg_value;
            else
                height_reg = reg_value;
        endfunction

        function int active_span(logic [CFG_DATA_W-1:0] reg_value, int limit);
            return (int'(reg_value) > limit) ? limit : int'(reg_value);
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void note_command(in_item_t item);
            out_item_t           res;
            bit [GRID_CELLS-1:0] snapshot;
            int                  w, h, idx, n, nx, ny;
            w   = active_span(width_reg, LGGE_MAX_WIDTH);
            h   = active_span(height_reg, LGGE_MAX_HEIGHT);
            res = '0;
            idx = int'(item.x_pos) * LGGE_MAX_HEIGHT + int'(item.y_pos);
            case (item.command)
                CMD_WRITE, CMD_READ:
                begin
                    if (int'(item.x_pos) >= w || int'(item.y_pos) >= h)
                        res.coord_error = 1'b1;
                    else if (item.command == CMD_WRITE)
                        cells[idx] = item.write_value;
                    else
                        res.cell_alive = cells[idx];
                end
                CMD_CLEAR:
                begin
                    cells = '0;
                end
                default:
                begin
                    snapshot = cells;
                    for (int x = 0; x < w; x++)
                    begin
                        for (int y = 0; y < h; y++)
                        begin
                            n = 0;
                            for (int dx = -1; dx <= 1; dx++)
                            begin
                                for (int dy = -1; dy <= 1; dy++)
                                begin
                                    nx = x + dx;
                                    ny = y + dy;
                                    if ((dx != 0 || dy != 0) && nx >= 0 && nx < w
                                        && ny >= 0 && ny < h)
                                        n += snapshot[nx * LGGE_MAX_HEIGHT + ny];
                                end
                            end
                            idx = x * LGGE_MAX_HEIGHT + y;
                            if (snapshot[idx])
                                cells[idx] = (n == 2 || n == 3);
                            else
                                cells[idx] = (n == 3);
                        end
                    end
                end
            endcase
            pending_results.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            result_count++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: none outstanding, got alive=%0b error=%0b",
                             result_count, got.cell_alive, got.coord_error);
                return;
            end
            want = pending_results.pop_front();
            if (got.cell_alive !== want.cell_alive || got.coord_error !== want.coord_error)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected alive=%0b error=%0b, got alive=%0b error=%0b",
                             result_count, want.cell_alive, want.coord_error,
                             got.cell_alive, got.coord_error);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  idle_on;
    logic                  hold_off_req;
    int                    quiet_cycles = 0;

    life_grid_scoreboard sb = new();

    lgge_stream_if #(.payload_t(in_item_t))  in_chan ();
    lgge_stream_if #(.payload_t(out_item_t)) out_chan ();

    life_grid_generation_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_chan   (in_chan),
        .out_chan  (out_chan)
    );

    always #1 clk = ~clk;

    function automatic int idle_gap();
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(8, 40));
        return int'($urandom_range(1, 3));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'($urandom_range(65, 127));
            3:       return GRID_SIZE_RESET;
            default: return CFG_DATA_W'($urandom_range(2, 16));
        endcase
    endfunction

    task automatic send_command(cmd_t command, int x, int y, bit value);
        in_item_t item;
        int       gap;
        item.command     = command;
        item.x_pos       = COORD_W'(x);
        item.y_pos       = COORD_W'(y);
        item.write_value = value;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_gap() : 0;
        if (gap > 0)
        begin
            in_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_chan.valid   <= 1'b1;
        in_chan.payload <= item;
        do @(posedge clk); while (!in_chan.ready);
        sb.note_command(item);
    endtask

    task automatic random_command(int w, int h);
        int   r, x, y;
        cmd_t command;
        r = $urandom_range(0, 99);
        command = (r < 45) ? CMD_WRITE : (r < 75) ? CMD_READ : (r < 95) ? CMD_STEP : CMD_CLEAR;
        if (w > 0 && h > 0 && $urandom_range(0, 9) < 8)
        begin
            x = $urandom_range(0, w - 1);
            y = $urandom_range(0, h - 1);
        end
        else
        begin
            x = $urandom_range(0, 63);
            y = $urandom_range(0, 63);
        end
        send_command(command, x, y, $urandom_range(0, 9) < 7);
    endtask

    task automatic drain();
        in_chan.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_grid_size(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GRID_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_index <= CFG_GRID_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_size(CFG_GRID_WIDTH, w);
        sb.set_size(CFG_GRID_HEIGHT, h);
    endtask

    initial
    begin : result_sink
        int stall_left;
        bit hold_off_done;
        stall_left     = 0;
        hold_off_done  = 1'b0;
        out_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_chan.valid && out_chan.ready)
                sb.check_result(out_chan.payload);
            if (hold_off_req && !hold_off_done)
            begin
                stall_left    = HOLD_OFF_CYCLES;
                hold_off_done = 1'b1;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0)
                stall_left = idle_gap();
            if (stall_left > 0)
            begin
                out_chan.ready <= 1'b0;
                stall_left--;
            end
            else
                out_chan.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int                    sent;
        int                    phase;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_GRID_WIDTH;
        cfg_wdata       <= '0;
        in_chan.valid   <= 1'b0;
        in_chan.payload <= '0;
        idle_on         <= 1'b1;
        hold_off_req    <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // corner L grows into a block, vertical blinker flips
        send_command(CMD_READ, 0, 0, 1'b1);
        send_command(CMD_WRITE, 0, 0, 1'b1);
        send_command(CMD_WRITE, 63, 63, 1'b1);
        send_command(CMD_WRITE, 62, 63, 1'b1);
        send_command(CMD_WRITE, 63, 62, 1'b1);
        send_command(CMD_WRITE, 10, 9, 1'b1);
        send_command(CMD_WRITE, 10, 10, 1'b1);
        send_command(CMD_WRITE, 10, 11, 1'b1);
        send_command(CMD_STEP, 0, 0, 1'b0);
        send_command(CMD_READ, 62, 62, 1'b0);
        send_command(CMD_READ, 9, 10, 1'b0);
        send_command(CMD_WRITE, 9, 10, 1'b0);
        send_command(CMD_READ, 9, 10, 1'b1);
        drain();

        set_grid_size(CFG_DATA_W'(127), CFG_DATA_W'(100));
        send_command(CMD_READ, 63, 63, 1'b0);
        send_command(CMD_STEP, 63, 63, 1'b1);
        send_command(CMD_READ, 63, 63, 1'b1);
        drain();

        set_grid_size('0, GRID_SIZE_RESET);
        send_command(CMD_WRITE, 0, 0, 1'b1);
        send_command(CMD_STEP, 21, 42, 1'b1);
        drain();
        set_grid_size(GRID_SIZE_RESET, '0);
        send_command(CMD_READ, 0, 0, 1'b0);
        drain();

        set_grid_size(CFG_DATA_W'(1), CFG_DATA_W'(8));
        send_command(CMD_WRITE, 1, 0, 1'b1);
        send_command(CMD_WRITE, 0, 8, 1'b1);
        send_command(CMD_WRITE, 0, 3, 1'b1);
        send_command(CMD_STEP, 0, 0, 1'b0);
        drain();

        set_grid_size(GRID_SIZE_RESET, GRID_SIZE_RESET);
        send_command(CMD_READ, 10, 10, 1'b0);
        send_command(CMD_READ, 63, 63, 1'b0);
        send_command(CMD_CLEAR, 63, 63, 1'b1);
        send_command(CMD_READ, 63, 63, 1'b1);
        drain();

        sent = 0;
        for (phase = 0; sent < RANDOM_ITEMS; phase++)
        begin
            w = pick_size();
            h = pick_size();
            set_grid_size(w, h);
            idle_on <= (phase != PRESSURE_PHASE);
            if (phase == PRESSURE_PHASE)
                hold_off_req <= 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                random_command(sb.active_span(w, LGGE_MAX_WIDTH),
                               sb.active_span(h, LGGE_MAX_HEIGHT));
                sent++;
            end
            drain();
        end

        repeat (16) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
design/lgge_pkg.sv
design/lgge_stream_if.sv
design/lgge_ctrl.sv
design/lgge_datapath.sv
design/life_grid_generation_engine.sv
tb/life_grid_generation_engine_tb.sv
